[design/pwm_pkg.sv]
// Shared types and constants for the page window mapper.
package pwm_pkg;

  localparam int ALU_W = 32;
  localparam int SUM_W = 26;
  localparam int ENTRY_W = 9;

  localparam logic [ENTRY_W-1:0] FREE_MARK = 9'h100;
  localparam logic [ALU_W-1:0] FLASH_PAGES = 32'd256;
  localparam logic [31:0] BASE_RESET = 32'h3c02_0000;

  localparam logic CMD_MAP = 1'b0;
  localparam logic CMD_UNMAP = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_ROOM = 2'd1,
    ST_RANGE   = 2'd2
  } pwm_status_t;

  typedef struct packed {
    logic        command;
    logic [23:0] flash_address;
    logic [23:0] byte_count;
    logic [6:0]  first_entry;
    logic [7:0]  entry_count;
  } pwm_req_t;

  typedef struct packed {
    pwm_status_t status;
    logic [31:0] mapped_address;
    logic [6:0]  mapped_first_entry;
    logic [7:0]  mapped_entry_count;
  } pwm_rsp_t;

  typedef struct packed {
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } pwm_alu_in_t;

endpackage

[design/pwm_ram.sv]
// Generic single-port-write, registered-read RAM.
module pwm_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 128,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/pwm_alu.sv]
// Shared adder with registered sum, used by the arithmetic steps of the sequencer.
module pwm_alu import pwm_pkg::*; (
  input  logic             clk,
  input  pwm_alu_in_t      op,
  output logic [ALU_W-1:0] sum
);

  always_ff @(posedge clk) begin
    sum <= op.a + op.b;
  end

endmodule

[design/pwm_engine.sv]
// Sequencer for table clear, free-entry scan, run checks, run writes and mapped-address sum.
module pwm_engine import pwm_pkg::*; #(
  parameter int TABLE_DEPTH = 128,
  parameter int FIRST_USABLE_ENTRY = 2,
  parameter int PAGE_SHIFT = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  pwm_req_t                       request,
  input  logic [31:0]                    base,
  output logic                           busy,
  output logic                           done,
  output pwm_rsp_t                       result,
  output logic                           ram_we,
  output logic [$clog2(TABLE_DEPTH)-1:0] ram_waddr,
  output logic [ENTRY_W-1:0]             ram_wdata,
  output logic [$clog2(TABLE_DEPTH)-1:0] ram_raddr,
  input  logic [ENTRY_W-1:0]             ram_rdata,
  output pwm_alu_in_t                    alu_op,
  input  logic [ALU_W-1:0]               alu_sum
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int PTR_W = (IDX_W + 1 > 9) ? IDX_W + 1 : 9;
  localparam logic [PTR_W-1:0] DEPTH_P = PTR_W'(TABLE_DEPTH);
  localparam logic [PTR_W-1:0] FUE_P = PTR_W'(FIRST_USABLE_ENTRY);
  localparam logic [ALU_W-1:0] DEPTH_A = ALU_W'(TABLE_DEPTH);
  localparam logic [ALU_W-1:0] PAGE_MASK = (ALU_W'(1) << PAGE_SHIFT) - ALU_W'(1);
  localparam logic [ALU_W-1:0] FUE_OFS_NEG =
    ALU_W'(0) - (ALU_W'(FIRST_USABLE_ENTRY) << PAGE_SHIFT);

  typedef enum logic [18:0] {
    S_CLEAR     = 19'h00001,
    S_CLEAR_INC = 19'h00002,
    S_IDLE      = 19'h00004,
    S_CNT1      = 19'h00008,
    S_CNT2      = 19'h00010,
    S_CNT3      = 19'h00020,
    S_SCAN_RD   = 19'h00040,
    S_SCAN_CHK  = 19'h00080,
    S_ROOM      = 19'h00100,
    S_ROOM_CHK  = 19'h00200,
    S_RANGE     = 19'h00400,
    S_RANGE_CHK = 19'h00800,
    S_WALK      = 19'h01000,
    S_WALK_INC  = 19'h02000,
    S_ADDR1     = 19'h04000,
    S_ADDR2     = 19'h08000,
    S_ADDR_OUT  = 19'h10000,
    S_UNMAP_END = 19'h20000,
    S_UNMAP_SET = 19'h40000
  } pwm_state_t;

  pwm_state_t        state;
  logic [PTR_W-1:0]  ptr;
  logic [PTR_W-1:0]  stop;
  logic [PTR_W-1:0]  start_idx;
  logic [SUM_W-1:0]  cnt;
  logic [7:0]        page;
  logic              cmd;
  logic [23:0]       fa;
  logic [23:0]       bytes;
  logic [ALU_W-1:0]  fpage;
  logic [ALU_W-1:0]  off;
  logic              walk_go;

  assign busy = (state != S_IDLE);
  assign fpage = ALU_W'(fa) >> PAGE_SHIFT;
  assign off = ALU_W'(fa) & PAGE_MASK;
  assign walk_go = (ptr < stop) && (ptr < DEPTH_P);

  assign ram_waddr = ptr[IDX_W-1:0];
  assign ram_raddr = ptr[IDX_W-1:0];
  assign ram_we = (state == S_CLEAR) || ((state == S_WALK) && walk_go);
  assign ram_wdata = ((state == S_CLEAR) || (cmd == CMD_UNMAP)) ? FREE_MARK
                                                                : {1'b0, page};

  always_comb begin
    alu_op = '0;
    case (state)
      S_CLEAR, S_SCAN_RD, S_WALK: begin
        alu_op.a = ALU_W'(ptr);
        alu_op.b = ALU_W'(1);
      end
      S_CNT1: begin
        alu_op.a = ALU_W'(bytes);
        alu_op.b = PAGE_MASK;
      end
      S_CNT2: begin
        alu_op.a = alu_sum;
        alu_op.b = off;
      end
      S_ROOM, S_UNMAP_END: begin
        alu_op.a = ALU_W'(ptr);
        alu_op.b = ALU_W'(cnt);
      end
      S_RANGE: begin
        alu_op.a = fpage;
        alu_op.b = ALU_W'(cnt);
      end
      S_ADDR1: begin
        alu_op.a = base;
        alu_op.b = (ALU_W'(start_idx) << PAGE_SHIFT) | off;
      end
      S_ADDR2: begin
        alu_op.a = alu_sum;
        alu_op.b = FUE_OFS_NEG;
      end
      default: begin
        alu_op = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      ptr <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          state <= S_CLEAR_INC;
        end
        S_CLEAR_INC: begin
          ptr <= alu_sum[PTR_W-1:0];
          state <= (alu_sum == DEPTH_A) ? S_IDLE : S_CLEAR;
        end
        S_IDLE: begin
          if (start) begin
            cmd <= request.command;
            fa <= request.flash_address;
            bytes <= request.byte_count;
            if (request.command == CMD_MAP) begin
              ptr <= FUE_P;
              state <= S_CNT1;
            end else begin
              ptr <= PTR_W'(request.first_entry);
              cnt <= SUM_W'(request.entry_count);
              state <= S_UNMAP_END;
            end
          end
        end
        S_UNMAP_END: begin
          state <= S_UNMAP_SET;
        end
        S_UNMAP_SET: begin
          stop <= alu_sum[PTR_W-1:0];
          state <= S_WALK;
        end
        S_CNT1: begin
          state <= S_CNT2;
        end
        S_CNT2: begin
          state <= S_CNT3;
        end
        S_CNT3: begin
          cnt <= SUM_W'(alu_sum >> PAGE_SHIFT);
          state <= S_SCAN_RD;
        end
        S_SCAN_RD: begin
          if (ptr >= DEPTH_P) begin
            start_idx <= ptr;
            state <= S_ROOM;
          end else begin
            state <= S_SCAN_CHK;
          end
        end
        S_SCAN_CHK: begin
          if (ram_rdata == FREE_MARK) begin
            start_idx <= ptr;
            state <= S_ROOM;
          end else begin
            ptr <= alu_sum[PTR_W-1:0];
            state <= S_SCAN_RD;
          end
        end
        S_ROOM: begin
          state <= S_ROOM_CHK;
        end
        S_ROOM_CHK: begin
          if (alu_sum >= DEPTH_A) begin
            result <= '{status: ST_NO_ROOM, mapped_address: '0,
                        mapped_first_entry: '0, mapped_entry_count: '0};
            done <= 1'b1;
            state <= S_IDLE;
          end else begin
            stop <= alu_sum[PTR_W-1:0];
            state <= S_RANGE;
          end
        end
        S_RANGE: begin
          state <= S_RANGE_CHK;
        end
        S_RANGE_CHK: begin
          if ((cnt != '0) && (alu_sum > FLASH_PAGES)) begin
            result <= '{status: ST_RANGE, mapped_address: '0,
                        mapped_first_entry: '0, mapped_entry_count: '0};
            done <= 1'b1;
            state <= S_IDLE;
          end else begin
            page <= fpage[7:0];
            state <= S_WALK;
          end
        end
        S_WALK: begin
          if (walk_go) begin
            state <= S_WALK_INC;
          end else if (cmd == CMD_MAP) begin
            state <= S_ADDR1;
          end else begin
            result <= '{status: ST_OK, mapped_address: '0,
                        mapped_first_entry: '0, mapped_entry_count: '0};
            done <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_WALK_INC: begin
          ptr <= alu_sum[PTR_W-1:0];
          page <= page + 8'd1;
          state <= S_WALK;
        end
        S_ADDR1: begin
          state <= S_ADDR2;
        end
        S_ADDR2: begin
          state <= S_ADDR_OUT;
        end
        S_ADDR_OUT: begin
          result <= '{status: ST_OK, mapped_address: alu_sum,
                      mapped_first_entry: start_idx[6:0],
                      mapped_entry_count: cnt[7:0]};
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[design/page_window_mapper.sv]
// Page window mapper top level: base register, shared adder, page table RAM, sequencer.
// Map: count pages, scan for a free entry, check room and range, write the run, then form
//   the address; scan and write loops step one table entry at a time through the shared adder.
// Unmap: marks the run from first_entry free. One request at a time; busy stays high.
// The result appears with done, which is high for one cycle; the receiver cannot stall it.
// Reset: a clearing pass marks every entry free; busy is high.
module page_window_mapper import pwm_pkg::*; #(
  parameter int TABLE_DEPTH = 128,
  parameter int FIRST_USABLE_ENTRY = 2,
  parameter int PAGE_SHIFT = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  pwm_req_t    request,
  output logic        done,
  output pwm_rsp_t    result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);

  logic [31:0]        base;
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [IDX_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  pwm_alu_in_t        alu_op;
  logic [ALU_W-1:0]   alu_sum;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base <= BASE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      base <= cfg_data;
    end
  end

  pwm_alu u_alu (
    .clk (clk),
    .op  (alu_op),
    .sum (alu_sum)
  );

  pwm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pwm_engine #(
    .TABLE_DEPTH        (TABLE_DEPTH),
    .FIRST_USABLE_ENTRY (FIRST_USABLE_ENTRY),
    .PAGE_SHIFT         (PAGE_SHIFT)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .request   (request),
    .base      (base),
    .busy      (busy),
    .done      (done),
    .result    (result),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .alu_op    (alu_op),
    .alu_sum   (alu_sum)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> (!busy && $past(busy)))
    else $error("result word without a finished request");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != ST_OK) |->
      (result.mapped_address == 32'd0 && result.mapped_entry_count == 8'd0))
    else $error("failed map returned nonzero fields");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !ram_we)
    else $error("table written while idle");

endmodule
